FILE: design/mpcd_pkg.sv
// package for the multi-protocol command deframer
// constants, codes and the crc step function; no dependencies
package mpcd_pkg;
  localparam int unsigned BufDepthDef   = 128;
  localparam int unsigned HeadLenDef    = 8;
  localparam int unsigned FaLenDef      = 7;
  localparam int unsigned A5LenDef      = 8;
  localparam int unsigned TermMinDef    = 3;
  localparam int unsigned TermMaxDef    = 16;
  localparam int unsigned MaxResults    = 64;

  localparam logic [7:0] SyncHead = 8'hAA;
  localparam logic [7:0] SyncFa   = 8'hFA;
  localparam logic [7:0] SyncA5   = 8'hA5;
  localparam logic [7:0] TermMask = 8'hF0;
  localparam logic [7:0] TermSync = 8'h80;
  localparam logic [7:0] TermEnd  = 8'hFF;
  localparam logic [7:0] ModeVar  = 8'h04;
  localparam logic [7:0] CmdVar   = 8'h00;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam int unsigned PosMode  = 2;
  localparam int unsigned PosCmd   = 3;
  localparam int unsigned PosLenHi = 5;
  localparam int unsigned PosLenLo = 6;

  typedef enum logic [1:0] {
    PROTO_HEAD = 2'd0,
    PROTO_FA   = 2'd1,
    PROTO_TERM = 2'd2,
    PROTO_A5   = 2'd3
  } proto_e;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction
endpackage

FILE: design/mpcd_ring.sv
// ring buffer memory of the deframer, one write port and one registered read port
// depends on mpcd_pkg
module mpcd_ring #(
  parameter int unsigned BufDepth = mpcd_pkg::BufDepthDef,
  localparam int unsigned AW = $clog2(BufDepth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  import mpcd_pkg::*;
  logic [7:0] mem [BufDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: design/multi_protocol_command_deframer.sv
// multi-protocol command deframer, top level
// uses mpcd_pkg and mpcd_ring
//
// input channel: rx_byte_i with byte_present_i; byte_present_i 0 is a poll
// each accepted input appends its byte to the ring (or flags overflow when the
// ring is full), then a sequencer scans the held bytes from the read position
// through the single registered read port
// for a start candidate the sequencer gathers a header, walks a checksum, crc or
// terminator and then emits the frame bytes, each held until out_ready_i; a failed
// check drops the held bytes up to and including the start byte and restarts the
// scan
// a good frame is sent as one output transfer per byte with protocol_o and
// frame_last_o; an input that yields no frame but overflowed gives one transfer
// with byte_valid_o 0
// in_ready_o is high only in the idle state, so one input is taken at a time
// reset empties the ring and clears the pending variable length; ring contents
// are not cleared. when the receiver stalls, the block holds the current
// transfer and takes no input until the frame is delivered
module multi_protocol_command_deframer #(
  parameter int unsigned BufDepth = mpcd_pkg::BufDepthDef,
  parameter int unsigned HeadLen  = mpcd_pkg::HeadLenDef,
  parameter int unsigned FaLen    = mpcd_pkg::FaLenDef,
  parameter int unsigned A5Len    = mpcd_pkg::A5LenDef,
  parameter int unsigned TermMin  = mpcd_pkg::TermMinDef,
  parameter int unsigned TermMax  = mpcd_pkg::TermMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       byte_present_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] protocol_o,
  output logic       frame_last_o,
  output logic       overflow_o
);
  import mpcd_pkg::*;

  localparam int unsigned AW = $clog2(BufDepth);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned Limit = (BufDepth / 2 < MaxResults) ? BufDepth / 2 : MaxResults;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SCAN  = 13'b0000000000010,
    S_CHAR  = 13'b0000000000100,
    S_HRD   = 13'b0000000001000,
    S_HDAT  = 13'b0000000010000,
    S_WRD   = 13'b0000000100000,
    S_WDAT  = 13'b0000001000000,
    S_JUDGE = 13'b0000010000000,
    S_ERD   = 13'b0000100000000,
    S_EDAT  = 13'b0001000000000,
    S_EOUT  = 13'b0010000000000,
    S_OVF   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  // walk kinds
  typedef enum logic [2:0] {
    W_XOR  = 3'd0,
    W_SUMF = 3'd1,
    W_SUMA = 3'd2,
    W_CRC  = 3'd3,
    W_TERM = 3'd4
  } walk_e;

  state_e state_q, state_d;
  walk_e  walk_q, walk_d;
  logic [AW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CW-1:0] held_q, held_d;
  logic [15:0]   pend_q, pend_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] i_q, i_d;       // scan offset
  logic [CW-1:0] k_q, k_d;       // offset within frame
  logic [CW-1:0] len_q, len_d;
  logic [7:0]    mode_q, mode_d, cmd_q, cmd_d, lhi_q, lhi_d, llo_q, llo_d;
  logic [15:0]   acc_q, acc_d;   // xor, sum or crc
  logic [7:0]    prev_q, prev_d;
  logic [1:0]    proto_q, proto_d;
  logic [7:0]    ob_q, ob_d;
  logic          olast_q, olast_d, ovld_q, ovld_d;
  logic          var_q, var_d;   // variable header whose xor is being checked

  logic          we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  mpcd_ring #(.BufDepth(BufDepth)) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_q),
    .wdata_i(rx_byte_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [CW-1:0] remain;
  logic [16:0]   vlen;
  logic [CW+1:0] idx;
  assign remain = held_q - i_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EOUT) || (state_q == S_OVF);
  assign frame_byte_o = ob_q;
  assign byte_valid_o = ovld_q;
  assign protocol_o = proto_q;
  assign frame_last_o = olast_q;
  assign overflow_o = ovf_q;

  always_comb begin
    state_d = state_q; walk_d = walk_q; rd_d = rd_q; wr_d = wr_q; held_d = held_q;
    pend_d = pend_q; ovf_d = ovf_q; i_d = i_q; k_d = k_q; len_d = len_q;
    mode_d = mode_q; cmd_d = cmd_q; lhi_d = lhi_q; llo_d = llo_q; acc_d = acc_q;
    prev_d = prev_q; proto_d = proto_q; ob_d = ob_q; olast_d = olast_q;
    ovld_d = ovld_q; var_d = var_q;
    we = 1'b0;
    vlen = 17'd0;
    idx = {2'b00, i_q} + {2'b00, k_q};
    raddr = rd_q + idx[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ovf_d = 1'b0;
          if (byte_present_i) begin
            if (held_q >= CW'(BufDepth)) begin
              ovf_d = 1'b1;
            end else begin
              we = 1'b1;
              wr_d = wr_q + AW'(1);
              held_d = held_q + CW'(1);
            end
          end
          i_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // restart point and per-offset read of the candidate start byte
        k_d = '0;
        if (i_q >= held_q) begin
          rd_d = rd_q + held_q[AW-1:0];
          held_d = '0;
          pend_d = '0;
          state_d = ovf_q ? S_OVF : S_DONE;
        end else begin
          raddr = rd_q + i_q[AW-1:0];
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        acc_d = '0;
        if (rdata == SyncHead) begin
          k_d = CW'(PosMode);
          if (remain + CW'(1) >= CW'(HeadLen) && pend_q == 16'd0) begin
            state_d = S_HRD;
          end else begin
            state_d = S_JUDGE;
          end
        end else if (rdata == SyncFa) begin
          if (remain < CW'(FaLen)) begin
            state_d = S_DONE;
          end else begin
            len_d = CW'(FaLen); proto_d = PROTO_FA; walk_d = W_SUMF;
            k_d = CW'(2); state_d = S_WRD;
          end
        end else if (rdata == SyncA5) begin
          if (remain < CW'(A5Len)) begin
            state_d = S_DONE;
          end else begin
            len_d = CW'(A5Len); proto_d = PROTO_A5; walk_d = W_SUMA;
            k_d = CW'(1); state_d = S_WRD;
          end
        end else if ((rdata & TermMask) == TermSync) begin
          if (remain < CW'(TermMin)) begin
            state_d = S_DONE;
          end else begin
            proto_d = PROTO_TERM; walk_d = W_TERM;
            k_d = CW'(TermMin - 1); state_d = S_WRD;
          end
        end else begin
          i_d = i_q + CW'(1);
          state_d = S_SCAN;
        end
        if (state_d == S_DONE) begin
          rd_d = rd_q + i_q[AW-1:0];
          held_d = held_q - i_q;
        end
      end
      S_HRD: begin
        state_d = S_HDAT;
      end
      S_HDAT: begin
        // gather mode, command and length bytes
        if (k_q == CW'(PosMode)) begin
          mode_d = rdata; k_d = CW'(PosCmd); state_d = S_HRD;
        end else if (k_q == CW'(PosCmd)) begin
          cmd_d = rdata; k_d = CW'(PosLenHi); state_d = S_HRD;
        end else if (k_q == CW'(PosLenHi)) begin
          lhi_d = rdata; k_d = CW'(PosLenLo); state_d = S_HRD;
        end else begin
          llo_d = rdata;
          if (mode_q == ModeVar && cmd_q == CmdVar && remain >= CW'(HeadLen)) begin
            walk_d = W_XOR; len_d = CW'(HeadLen); k_d = '0; var_d = 1'b1;
            state_d = S_WRD;
          end else begin
            state_d = S_JUDGE;
          end
        end
      end
      S_WRD: begin
        state_d = S_WDAT;
      end
      S_WDAT: begin
        // one walk step per byte
        unique case (walk_q)
          W_XOR: begin
            if (k_q + CW'(1) == CW'(HeadLen)) begin
              if (acc_q[7:0] == rdata) begin
                pend_d = {lhi_q, llo_q};
                var_d = 1'b0;
                state_d = S_JUDGE;
              end else begin
                rd_d = rd_q + i_q[AW-1:0] + AW'(1);
                held_d = held_q - i_q - CW'(1);
                if (!var_q) pend_d = '0;
                var_d = 1'b0;
                i_d = '0; state_d = S_SCAN;
              end
            end else begin
              acc_d = acc_q ^ {8'h00, rdata};
              k_d = k_q + CW'(1); state_d = S_WRD;
            end
          end
          W_SUMF, W_SUMA: begin
            if (k_q + CW'(1) == len_q) begin
              if (acc_q[7:0] == rdata) begin
                k_d = '0; state_d = S_ERD;
              end else begin
                rd_d = rd_q + i_q[AW-1:0] + AW'(1);
                held_d = held_q - i_q - CW'(1);
                i_d = '0; state_d = S_SCAN;
              end
            end else begin
              acc_d = acc_q + {8'h00, rdata};
              k_d = k_q + CW'(1); state_d = S_WRD;
            end
          end
          W_CRC: begin
            if (k_q + CW'(2) < len_q) begin
              acc_d = crc_byte(acc_q, rdata);
              k_d = k_q + CW'(1); state_d = S_WRD;
            end else if (k_q + CW'(2) == len_q) begin
              prev_d = rdata; k_d = k_q + CW'(1); state_d = S_WRD;
            end else begin
              if (acc_q == {prev_q, rdata}) begin
                k_d = '0; state_d = S_ERD;
              end else begin
                rd_d = rd_q + i_q[AW-1:0] + AW'(1);
                held_d = held_q - i_q - CW'(1);
                i_d = '0; state_d = S_SCAN;
              end
            end
          end
          default: begin
            if (rdata == TermEnd) begin
              if (k_q + CW'(1) > CW'(TermMax)) begin
                rd_d = rd_q + i_q[AW-1:0] + AW'(1);
                held_d = held_q - i_q - CW'(1);
                i_d = '0; state_d = S_SCAN;
              end else begin
                len_d = k_q + CW'(1); k_d = '0; state_d = S_ERD;
              end
            end else if (k_q + CW'(1) < remain) begin
              k_d = k_q + CW'(1); state_d = S_WRD;
            end else if (remain >= CW'(TermMax)) begin
              rd_d = rd_q + i_q[AW-1:0] + AW'(1);
              held_d = held_q - i_q - CW'(1);
              i_d = '0; state_d = S_SCAN;
            end else begin
              rd_d = rd_q + i_q[AW-1:0];
              held_d = held_q - i_q;
              state_d = ovf_q ? S_OVF : S_DONE;
            end
          end
        endcase
      end
      S_JUDGE: begin
        // header length decision
        if (pend_q != 16'd0) begin
          vlen = {1'b0, pend_q} + 17'(HeadLen);
        end else if (remain + CW'(1) >= CW'(HeadLen) && mode_q == ModeVar
                     && cmd_q == CmdVar) begin
          vlen = {1'b0, lhi_q, llo_q} + 17'(HeadLen);
        end else begin
          vlen = 17'(HeadLen);
        end
        proto_d = PROTO_HEAD;
        if (vlen > 17'(Limit)) begin
          rd_d = rd_q + i_q[AW-1:0] + AW'(1);
          held_d = held_q - i_q - CW'(1);
          pend_d = '0; i_d = '0; state_d = S_SCAN;
        end else if (vlen > 17'(remain)) begin
          rd_d = rd_q + i_q[AW-1:0];
          held_d = held_q - i_q;
          state_d = ovf_q ? S_OVF : S_DONE;
        end else if (vlen == 17'(HeadLen)) begin
          len_d = CW'(HeadLen); walk_d = W_XOR; var_d = 1'b0;
          acc_d = '0; k_d = '0;
          state_d = S_WRD;
          // a good xor goes straight to emit through xor_fixed_ok; flag with len == headlen
          pend_d = '0;
          mode_d = 8'h00;
        end else begin
          pend_d = '0;
          len_d = vlen[CW-1:0];
          if (vlen - 17'(HeadLen) < 17'd2) begin
            rd_d = rd_q + i_q[AW-1:0] + AW'(1);
            held_d = held_q - i_q - CW'(1);
            i_d = '0; state_d = S_SCAN;
          end else begin
            walk_d = W_CRC; acc_d = CrcInit; k_d = CW'(HeadLen); state_d = S_WRD;
          end
        end
      end
      S_ERD: begin
        state_d = S_EDAT;
      end
      S_EDAT: begin
        ob_d = rdata; ovld_d = 1'b1;
        olast_d = (k_q + CW'(1) == len_q);
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready_i) begin
          if (olast_q) begin
            rd_d = rd_q + i_q[AW-1:0] + len_q[AW-1:0];
            held_d = held_q - i_q - len_q;
            state_d = S_IDLE;
          end else begin
            k_d = k_q + CW'(1); state_d = S_ERD;
          end
        end
      end
      S_OVF: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (state_d == S_DONE && ovf_q) state_d = S_OVF;
    if (state_q == S_OVF || state_d == S_OVF) begin
      ob_d = (state_d == S_OVF) ? 8'h00 : ob_d;
      ovld_d = (state_d == S_OVF) ? 1'b0 : ovld_d;
      olast_d = (state_d == S_OVF) ? 1'b0 : olast_d;
      proto_d = (state_d == S_OVF) ? PROTO_HEAD : proto_d;
    end
    if (state_q == S_DONE) state_d = S_IDLE;
  end

  // a fixed header with good xor: walk returns to judge with pend set; redirect
  logic xor_fixed_ok;
  assign xor_fixed_ok = (state_q == S_WDAT) && (walk_q == W_XOR) && !var_q
                        && (k_q + CW'(1) == CW'(HeadLen)) && (acc_q[7:0] == rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_q <= '0; wr_q <= '0; held_q <= '0; pend_q <= '0;
      ovf_q <= 1'b0; var_q <= 1'b0;
    end else begin
      state_q <= xor_fixed_ok ? S_ERD : state_d;
      rd_q <= rd_d; wr_q <= wr_d; held_q <= held_d;
      pend_q <= xor_fixed_ok ? 16'd0 : pend_d;
      ovf_q <= ovf_d; var_q <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d; i_q <= i_d; len_q <= len_d;
    k_q <= xor_fixed_ok ? '0 : k_d;
    mode_q <= mode_d; cmd_q <= cmd_d; lhi_q <= lhi_d; llo_q <= llo_d;
    acc_q <= acc_d; prev_q <= prev_d; proto_q <= proto_d; ob_q <= ob_d;
    olast_q <= olast_d; ovld_q <= ovld_d;
  end
endmodule

FILE: design/mpcd_checker.sv
// port checker for the deframer, with bind to the top level
// depends on multi_protocol_command_deframer ports only
module mpcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_o,
  input logic       byte_valid_o,
  input logic       frame_last_o,
  input logic       overflow_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while output pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o))
    else $error("output dropped under stall");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> overflow_o && !frame_last_o)
    else $error("empty transfer without overflow");
endmodule

bind multi_protocol_command_deframer mpcd_checker u_mpcd_checker (.*);

FILE: tb/tb_multi_protocol_command_deframer.sv
// self-checking testbench for the multi-protocol command deframer
// predicts every output transfer from a behavioral copy of the scanner;
// depends on mpcd_pkg and the deframer rtl
module tb_multi_protocol_command_deframer;
  import mpcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingDepth  = 128;
  localparam int unsigned HdrLen     = 8;
  localparam int unsigned FaLen      = 7;
  localparam int unsigned A5Len      = 8;
  localparam int unsigned TermMinLen = 3;
  localparam int unsigned TermMaxLen = 16;
  localparam int unsigned FrameLimit = 64;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [7:0] rx;
    logic       present;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    proto_e     proto;
    logic       last;
    logic       ovf;
  } frame_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       byte_present = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       byte_valid;
  logic [1:0] protocol;
  logic       frame_last;
  logic       overflow;

  rx_item_t    rx_items[$];
  frame_beat_t beats_due[$];
  int          n_accepted = 0;
  int          n_errors = 0;
  int          cycles = 0;

  logic [7:0] ring[RingDepth];
  int         rd_pos, wr_pos, held, var_pending;

  always #5 clk_i = ~clk_i;

  multi_protocol_command_deframer i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .rx_byte_i(rx_byte), .byte_present_i(byte_present),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .frame_byte_o(frame_byte), .byte_valid_o(byte_valid),
    .protocol_o(protocol), .frame_last_o(frame_last), .overflow_o(overflow)
  );

  // ---------------- predictor
  function automatic logic [7:0] ring_at(int k);
    return ring[(rd_pos + k) % RingDepth];
  endfunction

  function automatic void drop(int n);
    if (n > held) n = held;
    rd_pos = (rd_pos + n) % RingDepth;
    held -= n;
  endfunction

  function automatic bit hdr_xor_good(int s);
    logic [7:0] x = 8'h00;
    for (int k = 0; k + 1 < HdrLen; k++) x ^= ring_at(s + k);
    return x == ring_at(s + HdrLen - 1);
  endfunction

  function automatic bit add_sum_good(int s, int from, int len);
    logic [7:0] sum = 8'h00;
    for (int k = from; k + 1 < len; k++) sum += ring_at(s + k);
    return sum == ring_at(s + len - 1);
  endfunction

  function automatic logic [15:0] modbus_crc(logic [15:0] c, logic [7:0] b);
    c ^= {8'h00, b};
    for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic bit var_crc_good(int s, int len);
    logic [15:0] c = 16'hFFFF;
    for (int k = HdrLen; k + 2 < len; k++) c = modbus_crc(c, ring_at(s + k));
    return c == {ring_at(s + len - 2), ring_at(s + len - 1)};
  endfunction

  function automatic int send_frame(int s, int len, proto_e p, logic ovf);
    frame_beat_t b;
    for (int k = 0; k < len; k++) begin
      b.data = ring_at(s + k);
      b.valid = 1'b1;
      b.proto = p;
      b.last = (k + 1 == len);
      b.ovf = ovf;
      beats_due.push_back(b);
    end
    drop(s + len);
    return len;
  endfunction

  // -1 asks for another pass
  function automatic int scan_pass(logic ovf);
    int c, remain, field, len;
    for (int i = 0; i < held; i++) begin
      c = ring_at(i);
      remain = held - i;
      if (c == SyncHead) begin
        field = 0;
        if (remain + 1 >= HdrLen) begin
          if (var_pending != 0) begin
            field = var_pending & 16'hFFFF;
          end else if (ring_at(i + PosMode) == ModeVar && ring_at(i + PosCmd) == CmdVar) begin
            field = {ring_at(i + PosLenHi), ring_at(i + PosLenLo)};
            if (remain >= HdrLen) begin
              if (!hdr_xor_good(i)) begin
                drop(i + 1);
                return -1;
              end
              var_pending = field;
            end
          end
        end
        len = field + HdrLen;
        if (len > FrameLimit) begin
          drop(i + 1);
          var_pending = 0;
          return -1;
        end
        if (len > remain) begin
          drop(i);
          return 0;
        end
        if (len == HdrLen) begin
          if (hdr_xor_good(i)) return send_frame(i, len, PROTO_HEAD, ovf);
          drop(i + 1);
          var_pending = 0;
          return -1;
        end
        var_pending = 0;
        if (len - HdrLen >= 2 && var_crc_good(i, len)) return send_frame(i, len, PROTO_HEAD, ovf);
        drop(i + 1);
        return -1;
      end else if (c == SyncFa) begin
        if (remain < FaLen) begin
          drop(i);
          return 0;
        end
        if (add_sum_good(i, 2, FaLen)) return send_frame(i, FaLen, PROTO_FA, ovf);
        drop(i + 1);
        return -1;
      end else if ((c & TermMask) == TermSync) begin
        if (remain < TermMinLen) begin
          drop(i);
          return 0;
        end
        for (int k = TermMinLen - 1; k < remain; k++) begin
          if (ring_at(i + k) == TermEnd) begin
            if (k + 1 > TermMaxLen) begin
              drop(i + 1);
              return -1;
            end
            return send_frame(i, k + 1, PROTO_TERM, ovf);
          end
        end
        if (remain >= TermMaxLen) begin
          drop(i + 1);
          return -1;
        end
        drop(i);
        return 0;
      end else if (c == SyncA5) begin
        if (remain < A5Len) begin
          drop(i);
          return 0;
        end
        if (add_sum_good(i, 1, A5Len)) return send_frame(i, A5Len, PROTO_A5, ovf);
        drop(i + 1);
        return -1;
      end
    end
    drop(held);
    var_pending = 0;
    return 0;
  endfunction

  function automatic void predict_frames(logic [7:0] rx, logic present);
    logic ovf = 1'b0;
    int n = 0;
    frame_beat_t b;
    if (present) begin
      if (held >= RingDepth) begin
        ovf = 1'b1;
      end else begin
        ring[wr_pos] = rx;
        wr_pos = (wr_pos + 1) % RingDepth;
        held++;
      end
    end
    while (held > 0) begin
      n = scan_pass(ovf);
      if (n >= 0) break;
      n = 0;
    end
    if (n == 0 && ovf) begin
      b = '{data: 8'h00, valid: 1'b0, proto: PROTO_HEAD, last: 1'b0, ovf: 1'b1};
      beats_due.push_back(b);
    end
  endfunction

  // ---------------- stimulus builders
  function automatic void put(logic [7:0] b, logic p = 1'b1);
    rx_items.push_back('{rx: b, present: p});
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic void put_seq(logic [7:0] f[$], bit bad);
    if (bad) f[f.size() - 1] ^= 8'(1 << $urandom_range(7));
    foreach (f[k]) put(f[k]);
  endfunction

  function automatic void build_head(bit bad);
    logic [7:0] f[$];
    logic [7:0] x;
    f.push_back(SyncHead);
    for (int k = 1; k < HdrLen - 1; k++) f.push_back(rnd8());
    if (f[PosMode] == ModeVar) f[PosCmd] = f[PosCmd] | 8'h01;
    x = 8'h00;
    foreach (f[k]) x ^= f[k];
    f.push_back(x);
    put_seq(f, bad);
  endfunction

  // a length beyond the frame limit sends the header only
  function automatic void build_var(int field, bit bad);
    logic [7:0] f[$];
    logic [7:0] x;
    logic [15:0] c;
    f = '{SyncHead, rnd8(), ModeVar, CmdVar, rnd8(), 8'(field >> 8), 8'(field), 8'h00};
    x = 8'h00;
    for (int k = 0; k < HdrLen - 1; k++) x ^= f[k];
    f[HdrLen - 1] = x;
    if (field + HdrLen <= FrameLimit) begin
      c = 16'hFFFF;
      for (int k = 0; k + 2 < field; k++) begin
        f.push_back(rnd8());
        c = modbus_crc(c, f[f.size() - 1]);
      end
      if (field >= 2) begin
        f.push_back(c[15:8]);
        f.push_back(c[7:0]);
      end else begin
        for (int k = 0; k < field; k++) f.push_back(rnd8());
      end
    end
    put_seq(f, bad);
  endfunction

  function automatic void build_sum(logic [7:0] sync, int len, int from, bit bad);
    logic [7:0] f[$];
    logic [7:0] s;
    f.push_back(sync);
    for (int k = 1; k < len - 1; k++) f.push_back(rnd8());
    s = 8'h00;
    for (int k = from; k < len - 1; k++) s += f[k];
    f.push_back(s);
    put_seq(f, bad);
  endfunction

  function automatic void build_term(int len, bit no_end);
    logic [7:0] b;
    put(TermSync | 8'($urandom_range(15)));
    for (int k = 1; k < len - 1; k++) begin
      b = rnd8();
      if (b == TermEnd) b = 8'h7F;
      put(b);
    end
    put(no_end ? 8'h00 : TermEnd);
  endfunction

  // ---------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      int snd_idle, rcv_idle;
      rx_item_t it;
      snd_idle = (n_accepted < 55) ? 38 : (n_accepted < 110) ? 62 : 0;
      rcv_idle = (n_accepted < 55) ? 62 : (n_accepted < 110) ? 38 : 0;
      if (in_valid && in_ready) begin
        predict_frames(rx_byte, byte_present);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (rx_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
          it = rx_items.pop_front();
          in_valid <= 1'b1;
          rx_byte <= it.rx;
          byte_present <= it.present;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // ---------------- monitor
  always @(posedge clk_i) begin
    frame_beat_t e;
    cycles++;
    if (rst_ni && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected transfer byte %h valid %b proto %0d last %b ovf %b",
                 $time, frame_byte, byte_valid, protocol, frame_last, overflow);
        n_errors++;
      end else begin
        e = beats_due.pop_front();
        if (frame_byte !== e.data || byte_valid !== e.valid || protocol !== e.proto ||
            frame_last !== e.last || overflow !== e.ovf) begin
          $display("%0t: expected byte %h valid %b proto %0d last %b ovf %b", $time,
                   e.data, e.valid, e.proto, e.last, e.ovf);
          $display("%0t: actual   byte %h valid %b proto %0d last %b ovf %b", $time,
                   frame_byte, byte_valid, protocol, frame_last, overflow);
          n_errors++;
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("tb_multi_protocol_command_deframer: errors");
      $finish;
    end
  end

  initial begin
    int kind;
    rd_pos = 0;
    wr_pos = 0;
    held = 0;
    var_pending = 0;
    foreach (ring[k]) ring[k] = 8'h00;

    // directed
    put(8'h00, 1'b0);
    put(8'h00);
    put(8'hFF);
    build_head(0);
    build_head(1);
    build_var(2, 0);
    build_var(1, 0);
    build_var(57, 0);
    build_var(56, 0);
    build_sum(SyncFa, FaLen, 2, 0);
    build_sum(SyncFa, FaLen, 2, 1);
    build_sum(SyncA5, A5Len, 1, 0);
    build_term(TermMinLen, 0);
    build_term(TermMaxLen + 1, 1);
    put(8'h8F);
    put(8'hFF);
    put(8'hFF);
    put(8'h12, 1'b0);

    // random
    while (rx_items.size() < 160) begin
      kind = $urandom_range(11);
      case (kind)
        0: build_head($urandom_range(3) == 0);
        1, 2: build_var(($urandom_range(9) == 0) ? 56 : $urandom_range(2, 12),
                        $urandom_range(3) == 0);
        3: build_sum(SyncFa, FaLen, 2, $urandom_range(3) == 0);
        4: build_sum(SyncA5, A5Len, 1, $urandom_range(3) == 0);
        5, 6: build_term($urandom_range(TermMinLen, TermMaxLen + 1), $urandom_range(5) == 0);
        7: put(rnd8(), 1'b0);
        default: put(rnd8());
      endcase
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (rx_items.size() == 0 && !in_valid && beats_due.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (n_errors == 0 && beats_due.size() == 0) begin
      $display("tb_multi_protocol_command_deframer: clean");
    end else begin
      $display("tb_multi_protocol_command_deframer: errors");
    end
    $finish;
  end
endmodule

FILE: multi_protocol_command_deframer.f
design/mpcd_pkg.sv
design/mpcd_ring.sv
design/multi_protocol_command_deframer.sv
design/mpcd_checker.sv
tb/tb_multi_protocol_command_deframer.sv
